// ===== src/hdwt_pkg.sv =====
// shared types and constants for the multilevel integer haar transform core
// no dependencies; the core and hdwt_alu refer to this package by scoped names
package hdwt_pkg;

	localparam int unsigned SAMPLE_W       = 32;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned CFG_DATA_W     = 3;
	localparam int unsigned LOG_W          = 3;
	localparam int unsigned MAX_LENGTH_DEF = 64;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	localparam logic [LOG_W-1:0] RST_LENGTH_LOG2 = 3'd6;
	localparam logic [LOG_W-1:0] RST_LEVEL_COUNT = 3'd1;
	localparam logic             RST_DIRECTION   = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LENGTH_LOG2 = 2'd0,
		CFG_LEVEL_COUNT = 2'd1,
		CFG_DIRECTION   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PAIR,
		ST_COPY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic odd;
		logic inverse;
	} alu_ctrl_t;

endpackage

// ===== src/integer_haar_dwt_multilevel_core.sv =====
// top level of the multilevel integer haar transform core
// uses hdwt_pkg, hdwt_ram (sample store and scratch) and hdwt_alu
//
// channel   direction  signals                              meaning
// input     in         in_valid in_ready sample             one sample per transaction
// output    out        out_valid out_ready coefficient      one coefficient per transaction
//                      last_out                             marks the final one of a block
// config    in         cfg_valid cfg_ready cfg_index        register writes, always ready
//                      cfg_data
//
// loading accepts a sample whenever in_valid is high; in_ready is high only while loading
// each level over a span s = n >> level pairs s values through the alu into scratch
// and then copies them back, limited by the single read port of each ram
// output then streams one coefficient per cycle while out_ready is high
// out_ready low holds the current coefficient and pauses the store reads
// reset clears control state and the registers; ram contents are not cleared
module integer_haar_dwt_multilevel_core #(
	parameter int unsigned MAX_LENGTH = hdwt_pkg::MAX_LENGTH_DEF,
	parameter int unsigned DATA_WIDTH = hdwt_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [hdwt_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [hdwt_pkg::SAMPLE_W-1:0]  coefficient,
	output logic                                  last_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hdwt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hdwt_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int unsigned AW      = $clog2(MAX_LENGTH);
	localparam int unsigned FW      = $clog2(MAX_LENGTH + 1);
	localparam int unsigned LOG_MAX = FW - 1;
	localparam int unsigned LW      = hdwt_pkg::LOG_W;
	localparam int unsigned SW      = hdwt_pkg::SAMPLE_W;

	hdwt_pkg::state_t state_q, state_d;

	logic [LW-1:0]         len_q, lvl_q;
	logic                  dir_q;
	logic [LW-1:0]         lg_eff, lv_eff;
	logic [FW-1:0]         n_eff;
	logic [FW-1:0]         fill_q, fill_nx;
	logic [FW-1:0]         n_q, span, half, j_q, k_q;
	logic [LW-1:0]         levels_q, lv_q;
	logic                  inv_q, last_lvl;
	logic                  vld_s1;
	logic [AW-1:0]         idx_s1;
	logic                  ovalid_q, last_q;
	logic                  in_fire, out_fire, block_done;
	logic                  pair_go, copy_go, out_go;
	logic                  st_we, st_re, sc_we, sc_re;
	logic [AW-1:0]         st_waddr, st_raddr, sc_waddr, sc_raddr;
	logic [DATA_WIDTH-1:0] st_wdata, st_rdata, sc_rdata, alu_out, sample_ext;
	hdwt_pkg::alu_ctrl_t   alu_ctrl;

	// position of pair element j after deinterleave: evens low, odds high
	function automatic logic [AW-1:0] deint(input logic [FW-1:0] j, input logic [FW-1:0] h);
		logic [FW-1:0] r;
		r = j >> 1;
		if (j[0]) begin
			r = r + h;
		end
		return r[AW-1:0];
	endfunction

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= hdwt_pkg::RST_LENGTH_LOG2;
			lvl_q <= hdwt_pkg::RST_LEVEL_COUNT;
			dir_q <= hdwt_pkg::RST_DIRECTION;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hdwt_pkg::CFG_LENGTH_LOG2: len_q <= cfg_data;
				hdwt_pkg::CFG_LEVEL_COUNT: lvl_q <= cfg_data;
				hdwt_pkg::CFG_DIRECTION:   dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective length and level count
	always_comb begin
		lg_eff = len_q;
		if (lg_eff == '0) begin
			lg_eff = LW'(1);
		end
		if (lg_eff > LW'(LOG_MAX)) begin
			lg_eff = LW'(LOG_MAX);
		end
		lv_eff = (lvl_q < lg_eff) ? lvl_q : lg_eff;
		n_eff  = FW'(1) << lg_eff;
	end

	generate
		if (DATA_WIDTH > SW) begin : g_ext_wide
			assign sample_ext  = {{(DATA_WIDTH - SW){sample[SW-1]}}, sample};
			assign coefficient = $signed(st_rdata[SW-1:0]);
		end else if (DATA_WIDTH == SW) begin : g_ext_same
			assign sample_ext  = sample;
			assign coefficient = $signed(st_rdata);
		end else begin : g_ext_narrow
			assign sample_ext  = sample[DATA_WIDTH-1:0];
			assign coefficient = $signed({{(SW - DATA_WIDTH){1'b0}}, st_rdata});
		end
	endgenerate

	assign span       = n_q >> lv_q;
	assign half       = span >> 1;
	assign in_ready   = (state_q == hdwt_pkg::ST_LOAD);
	assign in_fire    = in_valid && in_ready;
	assign fill_nx    = fill_q + FW'(1);
	assign block_done = (fill_nx >= n_eff);
	assign out_valid  = ovalid_q;
	assign last_out   = last_q;
	assign out_fire   = ovalid_q && out_ready;
	assign pair_go    = (state_q == hdwt_pkg::ST_PAIR) && (j_q < span);
	assign copy_go    = (state_q == hdwt_pkg::ST_COPY) && (j_q < span);
	assign out_go     = (state_q == hdwt_pkg::ST_OUT) && (k_q < n_q) && (!ovalid_q || out_ready);
	assign last_lvl   = inv_q ? (lv_q == '0) : ((lv_q + LW'(1)) == levels_q);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hdwt_pkg::ST_LOAD: begin
				if (in_fire && block_done) begin
					state_d = (lv_eff == '0) ? hdwt_pkg::ST_OUT : hdwt_pkg::ST_PAIR;
				end
			end
			hdwt_pkg::ST_PAIR: begin
				if (j_q == span) begin
					state_d = hdwt_pkg::ST_COPY;
				end
			end
			hdwt_pkg::ST_COPY: begin
				if (j_q == span) begin
					state_d = last_lvl ? hdwt_pkg::ST_OUT : hdwt_pkg::ST_PAIR;
				end
			end
			hdwt_pkg::ST_OUT: begin
				if ((k_q == n_q) && (!ovalid_q || out_ready)) begin
					state_d = hdwt_pkg::ST_LOAD;
				end
			end
			default: state_d = hdwt_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hdwt_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			n_q      <= '0;
			levels_q <= '0;
			lv_q     <= '0;
			inv_q    <= 1'b0;
			j_q      <= '0;
			k_q      <= '0;
			vld_s1   <= 1'b0;
			ovalid_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				if (block_done) begin
					fill_q   <= '0;
					n_q      <= n_eff;
					levels_q <= lv_eff;
					inv_q    <= dir_q;
					lv_q     <= dir_q ? (lv_eff - LW'(1)) : '0;
				end else begin
					fill_q <= fill_nx;
				end
			end
			if ((state_q == hdwt_pkg::ST_COPY) && (j_q == span) && !last_lvl) begin
				lv_q <= inv_q ? (lv_q - LW'(1)) : (lv_q + LW'(1));
			end
			if (state_d != state_q) begin
				j_q <= '0;
			end else if (pair_go || copy_go) begin
				j_q <= j_q + FW'(1);
			end
			if (state_q != hdwt_pkg::ST_OUT) begin
				k_q <= '0;
			end else if (out_go) begin
				k_q <= k_q + FW'(1);
			end
			vld_s1 <= pair_go || copy_go;
			if (out_go) begin
				ovalid_q <= 1'b1;
				last_q   <= ((k_q + FW'(1)) == n_q);
			end else if (out_fire) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= j_q[AW-1:0];
	end

	// sample store: loads and copy-back write, pairing and output read
	assign st_we    = in_fire || (vld_s1 && (state_q == hdwt_pkg::ST_COPY));
	assign st_waddr = in_fire ? fill_q[AW-1:0] : idx_s1;
	assign st_wdata = in_fire ? sample_ext : sc_rdata;
	assign st_re    = pair_go || out_go;
	assign st_raddr = (state_q == hdwt_pkg::ST_OUT) ? k_q[AW-1:0] :
	                  (inv_q ? deint(j_q, half) : j_q[AW-1:0]);

	// scratch: pair results written, read back during copy
	assign sc_we    = vld_s1 && (state_q == hdwt_pkg::ST_PAIR);
	assign sc_waddr = inv_q ? idx_s1 : deint(FW'(idx_s1), half);
	assign sc_re    = copy_go;
	assign sc_raddr = j_q[AW-1:0];

	assign alu_ctrl.capture = sc_we && !idx_s1[0];
	assign alu_ctrl.odd     = idx_s1[0];
	assign alu_ctrl.inverse = inv_q;

	hdwt_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_LENGTH)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	hdwt_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_LENGTH)
	) u_scratch (
		.clk   (clk),
		.we    (sc_we),
		.waddr (sc_waddr),
		.wdata (alu_out),
		.re    (sc_re),
		.raddr (sc_raddr),
		.rdata (sc_rdata)
	);

	hdwt_alu #(
		.WIDTH (DATA_WIDTH)
	) u_alu (
		.clk  (clk),
		.ctrl (alu_ctrl),
		.din  (st_rdata),
		.dout (alu_out)
	);

	// results only appear in the output phase
	a_out_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == hdwt_pkg::ST_OUT))
		else $error("coefficient presented outside the output phase");

	// pipelined ram accesses only belong to pairing or copy-back
	a_s1_phase: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ((state_q == hdwt_pkg::ST_PAIR) || (state_q == hdwt_pkg::ST_COPY)))
		else $error("pair or copy write outside its phase");

	// output counter never passes the block length
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hdwt_pkg::ST_OUT) |-> (k_q <= n_q))
		else $error("output index beyond block length");

	// taking the final coefficient returns the block to loading
	a_last_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_out) |=> (state_q == hdwt_pkg::ST_LOAD))
		else $error("block did not return to loading after final coefficient");

endmodule

// ===== src/hdwt_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module hdwt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/hdwt_alu.sv =====
// shared lifting unit: holds the first value of a pair, then forms
// odd minus even (forward) or low plus high (inverse); depends on hdwt_pkg
module hdwt_alu #(
	parameter int unsigned WIDTH = hdwt_pkg::DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  hdwt_pkg::alu_ctrl_t ctrl,
	input  logic [WIDTH-1:0]    din,
	output logic [WIDTH-1:0]    dout
);

	logic [WIDTH-1:0] a_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			a_q <= din;
		end
	end

	always_comb begin
		if (!ctrl.odd) begin
			dout = din;
		end else if (ctrl.inverse) begin
			dout = a_q + din;
		end else begin
			dout = din - a_q;
		end
	end

endmodule
